### rtl/core/sgrs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sgrs_pkg;

  // Command codes carried in the op field
  localparam logic [1:0] OP_SET  = 2'd0;
  localparam logic [1:0] OP_MOVE = 2'd1;
  localparam logic [1:0] OP_TICK = 2'd2;

  // Channel select codes
  localparam logic [1:0] CH_A = 2'd0;
  localparam logic [1:0] CH_B = 2'd1;
  localparam logic [1:0] CH_C = 2'd2;

  localparam int UPC_W = 5;

  // Microcode operations
  localparam logic [3:0] UC_NOP     = 4'd0;
  localparam logic [3:0] UC_GLOAD   = 4'd1;
  localparam logic [3:0] UC_JZB     = 4'd2;
  localparam logic [3:0] UC_MODGO   = 4'd3;
  localparam logic [3:0] UC_WAIT    = 4'd4;
  localparam logic [3:0] UC_MODFIN  = 4'd5;
  localparam logic [3:0] UC_GSAVE   = 4'd6;
  localparam logic [3:0] UC_JZG     = 4'd7;
  localparam logic [3:0] UC_QGO     = 4'd8;
  localparam logic [3:0] UC_QSAVE   = 4'd9;
  localparam logic [3:0] UC_MOVEEND = 4'd10;
  localparam logic [3:0] UC_TICKACC = 4'd11;
  localparam logic [3:0] UC_TICKEND = 4'd12;

  // Program entry points
  localparam logic [UPC_W-1:0] PC_MOVE = 5'd0;
  localparam logic [UPC_W-1:0] PC_TICK = 5'd29;

  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] target_a;
    logic [15:0] target_b;
    logic [15:0] target_c;
    logic        half_steps;
  } cmd_item_t;

  typedef struct packed {
    logic [15:0] compare_a;
    logic [15:0] compare_b;
    logic [15:0] compare_c;
    logic        moving;
    logic        move_done;
  } rsp_item_t;

  typedef struct packed {
    logic [3:0]       op;
    logic [1:0]       ch;
    logic [UPC_W-1:0] jump;
  } uword_t;

  function automatic uword_t ucode(input logic [UPC_W-1:0] pc);
    uword_t w;
    w = '{op: UC_NOP, ch: CH_A, jump: 5'd0};
    case (pc)
      // gcd fold, channel A
      5'd0:  w = '{op: UC_GLOAD,   ch: CH_A, jump: 5'd0};
      5'd1:  w = '{op: UC_JZB,     ch: CH_A, jump: 5'd5};
      5'd2:  w = '{op: UC_MODGO,   ch: CH_A, jump: 5'd0};
      5'd3:  w = '{op: UC_WAIT,    ch: CH_A, jump: 5'd0};
      5'd4:  w = '{op: UC_MODFIN,  ch: CH_A, jump: 5'd1};
      5'd5:  w = '{op: UC_GSAVE,   ch: CH_A, jump: 5'd0};
      // channel B
      5'd6:  w = '{op: UC_GLOAD,   ch: CH_B, jump: 5'd0};
      5'd7:  w = '{op: UC_JZB,     ch: CH_B, jump: 5'd11};
      5'd8:  w = '{op: UC_MODGO,   ch: CH_B, jump: 5'd0};
      5'd9:  w = '{op: UC_WAIT,    ch: CH_B, jump: 5'd0};
      5'd10: w = '{op: UC_MODFIN,  ch: CH_B, jump: 5'd7};
      5'd11: w = '{op: UC_GSAVE,   ch: CH_B, jump: 5'd0};
      // channel C
      5'd12: w = '{op: UC_GLOAD,   ch: CH_C, jump: 5'd0};
      5'd13: w = '{op: UC_JZB,     ch: CH_C, jump: 5'd17};
      5'd14: w = '{op: UC_MODGO,   ch: CH_C, jump: 5'd0};
      5'd15: w = '{op: UC_WAIT,    ch: CH_C, jump: 5'd0};
      5'd16: w = '{op: UC_MODFIN,  ch: CH_C, jump: 5'd13};
      5'd17: w = '{op: UC_GSAVE,   ch: CH_C, jump: 5'd0};
      // per-channel step sizes
      5'd18: w = '{op: UC_JZG,     ch: CH_A, jump: 5'd28};
      5'd19: w = '{op: UC_QGO,     ch: CH_A, jump: 5'd0};
      5'd20: w = '{op: UC_WAIT,    ch: CH_A, jump: 5'd0};
      5'd21: w = '{op: UC_QSAVE,   ch: CH_A, jump: 5'd0};
      5'd22: w = '{op: UC_QGO,     ch: CH_B, jump: 5'd0};
      5'd23: w = '{op: UC_WAIT,    ch: CH_B, jump: 5'd0};
      5'd24: w = '{op: UC_QSAVE,   ch: CH_B, jump: 5'd0};
      5'd25: w = '{op: UC_QGO,     ch: CH_C, jump: 5'd0};
      5'd26: w = '{op: UC_WAIT,    ch: CH_C, jump: 5'd0};
      5'd27: w = '{op: UC_QSAVE,   ch: CH_C, jump: 5'd0};
      5'd28: w = '{op: UC_MOVEEND, ch: CH_A, jump: 5'd0};
      // step tick
      5'd29: w = '{op: UC_TICKACC, ch: CH_A, jump: 5'd0};
      5'd30: w = '{op: UC_TICKEND, ch: CH_A, jump: 5'd0};
      default: w = '{op: UC_NOP,   ch: CH_A, jump: 5'd0};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

### rtl/core/sgrs_cmd_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface sgrs_cmd_if;
  logic                 valid;
  logic                 ready;
  sgrs_pkg::cmd_item_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### rtl/core/sgrs_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface sgrs_rsp_if;
  logic                 valid;
  logic                 ready;
  sgrs_pkg::rsp_item_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### rtl/core/servo_gcd_ramp_stepper_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel  Dir  Handshake     Transaction
// -------  ---  ------------  -------------------------------------------------
// cmd      in   valid/ready   op, target_a/b/c, half_steps
// rsp      out  valid/ready   compare_a/b/c, moving, move_done (one per cmd)
//
// Set commands, idle ticks and unused op codes load the result register at
// the accept edge. A tick during a move runs in order: accept, accumulate,
// position update.
// A move runs the microcode with one shared divider for every Euclid remainder
// and every per-channel step size. A divider call holds the sequencer through
// launch, waits on the divider and save; a Euclid round adds a zero test.
// cmd.ready is low while the sequencer runs and while rsp holds an untaken
// result that is not being taken this cycle. Reset clears all positions.
module servo_gcd_ramp_stepper_top #(
  parameter int POS_BITS = 16
) (
  input  wire logic clk,
  input  wire logic rst,
  sgrs_cmd_if.sink  cmd,
  sgrs_rsp_if.source rsp
);

  import sgrs_pkg::*;

  localparam int AW = POS_BITS + 1;

  // Channel state
  logic [POS_BITS-1:0] start_pos [3];
  logic [POS_BITS-1:0] cur       [3];
  logic [POS_BITS-1:0] delta     [3];
  logic                dir_up    [3];
  logic [POS_BITS-1:0] quot      [3];
  logic [AW-1:0]       acc       [3];

  // Move state
  logic [POS_BITS-1:0] g;
  logic [POS_BITS-1:0] ra;
  logic [POS_BITS-1:0] rb;
  logic [AW-1:0]       idx;
  logic [AW-1:0]       total;
  logic                half;
  logic                busy;

  // Sequencer
  logic                run;
  logic [UPC_W-1:0]    pc;
  uword_t              uw;

  // Result register
  logic                out_valid;
  rsp_item_t           out_data;

  logic                cmd_take;
  logic [POS_BITS-1:0] tgt      [3];
  logic [31:0]         tgt_wide [3];
  logic [AW-1:0]       acc_sum  [3];
  logic [AW-1:0]       off      [3];
  logic [POS_BITS-1:0] pos_tick [3];
  logic                tick_last;

  logic                div_start;
  logic                div_busy;
  logic [POS_BITS-1:0] div_dividend;
  logic [POS_BITS-1:0] div_divisor;
  logic [POS_BITS-1:0] div_quo;
  logic [POS_BITS-1:0] div_rem;

  function automatic logic [15:0] low16(input logic [POS_BITS-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    return w[15:0];
  endfunction

  assign uw       = ucode(pc);
  assign cmd_take = cmd.valid && cmd.ready;

  // Accept only with the sequencer idle and room in the result register.
  assign cmd.ready = !run && (!out_valid || rsp.ready);
  assign rsp.valid = out_valid;
  assign rsp.data  = out_data;

  // Fit the 16-bit targets to the position width.
  assign tgt_wide[0] = {16'd0, cmd.data.target_a};
  assign tgt_wide[1] = {16'd0, cmd.data.target_b};
  assign tgt_wide[2] = {16'd0, cmd.data.target_c};

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      tgt[k]      = tgt_wide[k][POS_BITS-1:0];
      acc_sum[k]  = acc[k] + {1'b0, quot[k]};
      // Halve the accumulated offset in half-step mode, truncating.
      off[k]      = half ? {1'b0, acc[k][AW-1:1]} : acc[k];
      pos_tick[k] = dir_up[k] ? start_pos[k] + off[k][POS_BITS-1:0]
                              : start_pos[k] - off[k][POS_BITS-1:0];
    end
  end

  assign tick_last = idx >= total;

  // Shared divider: Euclid remainders, then delta / gcd per channel.
  assign div_start    = run && (uw.op == UC_MODGO || uw.op == UC_QGO);
  assign div_dividend = (uw.op == UC_QGO) ? delta[uw.ch] : ra;
  assign div_divisor  = (uw.op == UC_QGO) ? g : rb;

  sgrs_div #(
    .W (POS_BITS)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .busy      (div_busy),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      run       <= 1'b0;
      pc        <= '0;
      out_valid <= 1'b0;
      busy      <= 1'b0;
      half      <= 1'b0;
      idx       <= '0;
      total     <= '0;
      g         <= '0;
      for (int k = 0; k < 3; k++) begin
        start_pos[k] <= '0;
        cur[k]       <= '0;
        delta[k]     <= '0;
        dir_up[k]    <= 1'b0;
        quot[k]      <= '0;
        acc[k]       <= '0;
      end
    end else begin
      // Drop the result once taken; a new one below overrides.
      if (rsp.ready) begin
        out_valid <= 1'b0;
      end

      if (cmd_take) begin
        case (cmd.data.op)
          OP_SET: begin
            for (int k = 0; k < 3; k++) begin
              start_pos[k] <= tgt[k];
              cur[k]       <= tgt[k];
            end
            busy      <= 1'b0;
            idx       <= '0;
            out_valid <= 1'b1;
            out_data  <= '{compare_a: low16(tgt[0]), compare_b: low16(tgt[1]),
                           compare_c: low16(tgt[2]), moving: 1'b0,
                           move_done: 1'b0};
          end
          OP_MOVE: begin
            // Restart from the positions driven now; clear busy so the
            // channels read as resting while the divisor search runs.
            for (int k = 0; k < 3; k++) begin
              start_pos[k] <= cur[k];
              if (cur[k] > tgt[k]) begin
                delta[k]  <= cur[k] - tgt[k];
                dir_up[k] <= 1'b0;
              end else begin
                delta[k]  <= tgt[k] - cur[k];
                dir_up[k] <= 1'b1;
              end
            end
            half <= cmd.data.half_steps;
            g    <= '0;
            busy <= 1'b0;
            idx  <= '0;
            run  <= 1'b1;
            pc   <= PC_MOVE;
          end
          OP_TICK: begin
            if (busy) begin
              run <= 1'b1;
              pc  <= PC_TICK;
            end else begin
              out_valid <= 1'b1;
              out_data  <= '{compare_a: low16(cur[0]), compare_b: low16(cur[1]),
                             compare_c: low16(cur[2]), moving: 1'b0,
                             move_done: 1'b0};
            end
          end
          default: begin
            out_valid <= 1'b1;
            out_data  <= '{compare_a: low16(cur[0]), compare_b: low16(cur[1]),
                           compare_c: low16(cur[2]), moving: busy,
                           move_done: 1'b0};
          end
        endcase
      end

      if (run) begin
        case (uw.op)
          UC_GLOAD: begin
            ra <= g;
            rb <= delta[uw.ch];
            pc <= pc + 1'b1;
          end
          UC_JZB: begin
            pc <= (rb == '0) ? uw.jump : pc + 1'b1;
          end
          UC_WAIT: begin
            // Hold until the divider settles.
            if (!div_busy) begin
              pc <= pc + 1'b1;
            end
          end
          UC_MODFIN: begin
            ra <= rb;
            rb <= div_rem;
            pc <= uw.jump;
          end
          UC_GSAVE: begin
            g  <= ra;
            pc <= pc + 1'b1;
          end
          UC_JZG: begin
            pc <= (g == '0) ? uw.jump : pc + 1'b1;
          end
          UC_QSAVE: begin
            quot[uw.ch] <= div_quo;
            pc          <= pc + 1'b1;
          end
          UC_MOVEEND: begin
            run   <= 1'b0;
            busy  <= (g != '0);
            total <= half ? {g, 1'b0} : {1'b0, g};
            idx   <= '0;
            for (int k = 0; k < 3; k++) begin
              acc[k] <= '0;
            end
            out_valid <= 1'b1;
            out_data  <= '{compare_a: low16(cur[0]), compare_b: low16(cur[1]),
                           compare_c: low16(cur[2]), moving: (g != '0),
                           move_done: (g == '0)};
          end
          UC_TICKACC: begin
            idx <= idx + 1'b1;
            for (int k = 0; k < 3; k++) begin
              acc[k] <= acc_sum[k];
            end
            pc <= pc + 1'b1;
          end
          UC_TICKEND: begin
            run <= 1'b0;
            for (int k = 0; k < 3; k++) begin
              cur[k] <= pos_tick[k];
            end
            // Land on the targets and make them the new start.
            if (tick_last) begin
              for (int k = 0; k < 3; k++) begin
                start_pos[k] <= pos_tick[k];
              end
              busy <= 1'b0;
              idx  <= '0;
            end
            out_valid <= 1'b1;
            out_data  <= '{compare_a: low16(pos_tick[0]),
                           compare_b: low16(pos_tick[1]),
                           compare_c: low16(pos_tick[2]),
                           moving: !tick_last, move_done: tick_last};
          end
          default: begin
            // Divider launches and spare words just advance.
            pc <= pc + 1'b1;
          end
        endcase
      end
    end
  end

  // A move in progress always has a nonzero common divisor.
  a_busy_gcd: assert property (@(posedge clk) disable iff (rst)
    busy |-> g != '0)
    else $error("busy with zero common divisor");

  // At rest every channel drives its start position.
  a_rest_pos: assert property (@(posedge clk) disable iff (rst)
    !busy |-> (cur[0] == start_pos[0] && cur[1] == start_pos[1] &&
               cur[2] == start_pos[2]))
    else $error("resting channel away from its start position");

  // The result register is empty whenever the sequencer works on an item.
  a_run_empty: assert property (@(posedge clk) disable iff (rst)
    run |-> !out_valid)
    else $error("result pending while sequencer runs");

  // Never relaunch the divider while it is still iterating.
  a_div_free: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_busy)
    else $error("divider started while busy");

  // The step index never passes the step count.
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> idx <= total)
    else $error("step index beyond step count");

endmodule

`default_nettype wire

### rtl/core/sgrs_div.sv
`timescale 1ns / 1ps
`default_nettype none

// Restoring divider, one quotient bit per cycle.
module sgrs_div #(
  parameter int W = 16
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         start,
  input  wire logic [W-1:0] dividend,
  input  wire logic [W-1:0] divisor,
  output logic              busy,
  output logic [W-1:0]      quotient,
  output logic [W-1:0]      remainder
);

  localparam int CNT_W = $clog2(W + 1);

  logic [W-1:0]     rem;
  logic [W-1:0]     quo;
  logic [W-1:0]     dvs;
  logic [CNT_W-1:0] cnt;
  logic [W:0]       shifted;
  logic [W:0]       diff;
  logic             fits;

  assign shifted = {rem, quo[W-1]};
  assign diff    = shifted - {1'b0, dvs};
  assign fits    = ~diff[W];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      quo  <= dividend;
      rem  <= '0;
      dvs  <= divisor;
      cnt  <= CNT_W'(W);
      busy <= 1'b1;
    end else if (busy) begin
      rem <= fits ? diff[W-1:0] : shifted[W-1:0];
      quo <= {quo[W-2:0], fits};
      cnt <= cnt - 1'b1;
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

endmodule

`default_nettype wire
